// ===== hdl/elx_pkg.sv =====
package elx_pkg;

  // Width of the name length counter and of a run length in a command.
  localparam int unsigned NameLenW = 6;

  localparam logic [7:0]  CH_NUL        = 8'h00;
  localparam logic [7:0]  CH_ZERO       = 8'h30;
  localparam logic [7:0]  CH_X          = 8'h78;
  localparam logic [7:0]  CH_UNDERSCORE = 8'h5F;
  localparam logic [4:0]  NO_DIGIT      = 5'd16;

  typedef enum logic [2:0] {
    LM_IDLE   = 3'd0,
    LM_ZERO   = 3'd1,
    LM_PREFIX = 3'd2,
    LM_NUMBER = 3'd3,
    LM_NAME   = 3'd4,
    LM_HALT   = 3'd5
  } lex_mode_t;

  typedef enum logic [2:0] {
    K_SYMBOL = 3'd0,
    K_NUMBER = 3'd1,
    K_NAMECH = 3'd2,
    K_ENDOK  = 3'd3,
    K_BADCH  = 3'd4,
    K_EARLY  = 3'd5,
    K_BIG    = 3'd6,
    K_LONG   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_RES0,
    BK_RES1
  } back_state_t;

  typedef struct packed {
    logic        vld;
    kind_t       kind;
    logic [31:0] value;
  } res_t;

  // One command per item that has results: a name run first, then res0, then res1.
  typedef struct packed {
    logic [NameLenW-1:0] run_len;
    res_t                res0;
    res_t                res1;
  } cmd_t;

  function automatic logic is_alpha_(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_namech(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || is_alpha_(c);
  endfunction

  function automatic logic is_sym(input logic [7:0] c);
    return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
           (c == 8'h28) || (c == 8'h29);
  endfunction

  // Digit value, or NO_DIGIT when the byte is not a digit of the radix.
  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 5'(c - 8'h30);
    end else if (hex && c >= 8'h61 && c <= 8'h66) begin
      d = 5'(c - 8'h61 + 8'd10);
    end else if (hex && c >= 8'h41 && c <= 8'h46) begin
      d = 5'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

endpackage

// ===== hdl/elx_ram.sv =====
module elx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/elx_front.sv =====
module elx_front #(
  parameter int unsigned MAX_NAME_LEN = 32,
  parameter int unsigned AW           = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     in_char_code,
  input  logic           in_start_of_text,
  input  logic           in_push,
  output logic           in_full,
  input  logic           q_full,
  input  logic           run_done,
  output logic           cmd_push,
  output elx_pkg::cmd_t  cmd,
  output logic           buf_we,
  output logic [AW-1:0]  buf_waddr,
  output logic [7:0]     buf_wdata
);
  import elx_pkg::*;

  localparam logic [NameLenW-1:0] NameMax = NameLenW'(MAX_NAME_LEN);

  lex_mode_t             mode_r, mode_nxt;
  logic                  hex_r, hex_nxt;
  logic [31:0]           acc_r, acc_nxt;
  logic [NameLenW-1:0]   len_r, len_nxt;
  logic                  pend_r, pend_nxt;

  lex_mode_t             m;
  logic [31:0]           acc_e;
  logic                  hex_e;
  logic [NameLenW-1:0]   len_e;
  logic [31:0]           nacc;
  logic                  nhex;
  logic [4:0]            d;
  logic [35:0]           next_val;
  logic                  accept;
  logic                  do_idle;
  logic                  do_num;

  // A name run in flight holds its characters in the buffer, so no item
  // is taken until the back end has read all of them.
  assign in_full = q_full || pend_r;
  assign accept  = in_push && !in_full;

  always_comb begin
    m     = in_start_of_text ? LM_IDLE : mode_r;
    acc_e = in_start_of_text ? 32'd0 : acc_r;
    hex_e = in_start_of_text ? 1'b0 : hex_r;
    len_e = in_start_of_text ? '0 : len_r;

    // Number digit path, shared by the leading-zero and in-number modes.
    nacc = (m == LM_ZERO) ? 32'd0 : acc_e;
    nhex = (m == LM_ZERO) ? 1'b0 : hex_e;
    d    = digit_of(in_char_code, nhex);
    next_val = (nhex ? {acc_e, 4'b0000} : ({1'b0, nacc, 3'b000} + {3'b000, nacc, 1'b0}))
               + {31'd0, d};
    if (nhex) begin
      next_val = {nacc, 4'b0000} + {31'd0, d};
    end

    mode_nxt  = mode_r;
    hex_nxt   = hex_r;
    acc_nxt   = acc_r;
    len_nxt   = len_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    cmd_push  = 1'b0;
    buf_we    = 1'b0;
    buf_waddr = len_e[AW-1:0];
    buf_wdata = in_char_code;
    do_idle   = 1'b0;
    do_num    = 1'b0;

    if (run_done) begin
      pend_nxt = 1'b0;
    end

    if (accept) begin
      mode_nxt = m;
      hex_nxt  = hex_e;
      acc_nxt  = acc_e;
      len_nxt  = len_e;

      unique case (m)
        LM_IDLE: begin
          do_idle = 1'b1;
        end
        LM_ZERO: begin
          if (in_char_code == CH_X) begin
            hex_nxt  = 1'b1;
            mode_nxt = LM_PREFIX;
          end else begin
            do_num = 1'b1;
          end
        end
        LM_PREFIX: begin
          if (digit_of(in_char_code, 1'b1) == NO_DIGIT) begin
            cmd.res0.vld   = 1'b1;
            cmd.res0.kind  = (in_char_code == CH_NUL) ? K_EARLY : K_BADCH;
            cmd.res0.value = {24'd0, in_char_code};
            mode_nxt       = LM_HALT;
          end else begin
            acc_nxt  = {27'd0, digit_of(in_char_code, 1'b1)};
            mode_nxt = LM_NUMBER;
          end
        end
        LM_NUMBER: begin
          do_num = 1'b1;
        end
        LM_NAME: begin
          if (is_namech(in_char_code)) begin
            if (len_e >= NameMax) begin
              cmd.res0.vld   = 1'b1;
              cmd.res0.kind  = K_LONG;
              cmd.res0.value = {24'd0, in_char_code};
              len_nxt        = '0;
              mode_nxt       = LM_HALT;
            end else begin
              buf_we  = 1'b1;
              len_nxt = len_e + NameLenW'(1);
            end
          end else begin
            cmd.run_len = len_e;
            pend_nxt    = (len_e != '0);
            len_nxt     = '0;
            do_idle     = 1'b1;
          end
        end
        default: begin
          mode_nxt = LM_HALT;
        end
      endcase

      if (do_num) begin
        hex_nxt = nhex;
        if (d == NO_DIGIT) begin
          cmd.res0.vld   = 1'b1;
          cmd.res0.kind  = K_NUMBER;
          cmd.res0.value = nacc;
          do_idle        = 1'b1;
        end else if (|next_val[35:32]) begin
          cmd.res0.vld   = 1'b1;
          cmd.res0.kind  = K_BIG;
          cmd.res0.value = {24'd0, in_char_code};
          mode_nxt       = LM_HALT;
        end else begin
          acc_nxt  = next_val[31:0];
          mode_nxt = LM_NUMBER;
        end
      end

      // Start of a new token, from idle or after a name or number ends; its result always goes last.
      if (do_idle) begin
        mode_nxt = LM_IDLE;
        if (in_char_code == CH_ZERO) begin
          mode_nxt = LM_ZERO;
        end else if (in_char_code > CH_ZERO && in_char_code <= 8'h39) begin
          hex_nxt  = 1'b0;
          acc_nxt  = 32'(in_char_code - CH_ZERO);
          mode_nxt = LM_NUMBER;
        end else if (is_alpha_(in_char_code)) begin
          buf_we    = 1'b1;
          buf_waddr = '0;
          len_nxt   = NameLenW'(1);
          mode_nxt  = LM_NAME;
        end else if (is_sym(in_char_code)) begin
          cmd.res1.vld   = 1'b1;
          cmd.res1.kind  = K_SYMBOL;
          cmd.res1.value = {24'd0, in_char_code};
        end else if (in_char_code == CH_NUL) begin
          cmd.res1.vld   = 1'b1;
          cmd.res1.kind  = K_ENDOK;
          cmd.res1.value = 32'd0;
        end else begin
          cmd.res1.vld   = 1'b1;
          cmd.res1.kind  = K_BADCH;
          cmd.res1.value = {24'd0, in_char_code};
          mode_nxt       = LM_HALT;
        end
      end

      cmd_push = (cmd.run_len != '0) || cmd.res0.vld || cmd.res1.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= LM_IDLE;
      hex_r  <= 1'b0;
      acc_r  <= 32'd0;
      len_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      hex_r  <= hex_nxt;
      acc_r  <= acc_nxt;
      len_r  <= len_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

// ===== hdl/elx_cmdq.sv =====
module elx_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  elx_pkg::cmd_t  wdata,
  output logic           full,
  input  logic           pop,
  output elx_pkg::cmd_t  rdata,
  output logic           empty
);
  import elx_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt  = ~wp_r;
      cnt_nxt = cnt_nxt + 2'd1;
    end
    if (pop && !empty) begin
      rp_nxt  = ~rp_r;
      cnt_nxt = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/elx_back.sv =====
module elx_back #(
  parameter int unsigned MAX_NAME_LEN = 32,
  parameter int unsigned AW           = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  elx_pkg::cmd_t  q_data,
  output logic           q_pop,
  output logic [AW-1:0]  buf_raddr,
  input  logic [7:0]     buf_rdata,
  output logic           run_done,
  output logic [2:0]     out_kind,
  output logic [31:0]    out_value,
  output logic           out_last,
  output logic           out_empty,
  input  logic           out_pop
);
  import elx_pkg::*;

  back_state_t          st_r, st_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [NameLenW-1:0]  idx_r, idx_nxt;
  logic                 fetched_r, fetched_nxt;
  logic                 ov_r, ov_nxt;
  kind_t                ok_r, ok_nxt;
  logic [31:0]          oval_r, oval_nxt;
  logic                 olast_r, olast_nxt;
  logic                 slot_free;

  assign slot_free = !ov_r || out_pop;
  assign buf_raddr = idx_r[AW-1:0];
  assign out_kind  = ok_r;
  assign out_value = oval_r;
  assign out_last  = olast_r;
  assign out_empty = !ov_r;

  always_comb begin
    st_nxt      = st_r;
    cmd_nxt     = cmd_r;
    idx_nxt     = idx_r;
    fetched_nxt = fetched_r;
    ov_nxt      = ov_r && !out_pop;
    ok_nxt      = ok_r;
    oval_nxt    = oval_r;
    olast_nxt   = olast_r;
    q_pop       = 1'b0;
    run_done    = 1'b0;

    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_data;
          idx_nxt     = '0;
          fetched_nxt = 1'b0;
          if (q_data.run_len != '0) begin
            st_nxt = BK_RUN;
          end else if (q_data.res0.vld) begin
            st_nxt = BK_RES0;
          end else begin
            st_nxt = BK_RES1;
          end
        end
      end
      BK_RUN: begin
        if (!fetched_r) begin
          fetched_nxt = 1'b1;
        end else if (slot_free) begin
          ov_nxt      = 1'b1;
          ok_nxt      = K_NAMECH;
          oval_nxt    = {24'd0, buf_rdata};
          fetched_nxt = 1'b0;
          idx_nxt     = idx_r + NameLenW'(1);
          olast_nxt   = 1'b0;
          if (idx_r == cmd_r.run_len - NameLenW'(1)) begin
            run_done  = 1'b1;
            olast_nxt = !cmd_r.res0.vld && !cmd_r.res1.vld;
            if (cmd_r.res0.vld) begin
              st_nxt = BK_RES0;
            end else if (cmd_r.res1.vld) begin
              st_nxt = BK_RES1;
            end else begin
              st_nxt = BK_IDLE;
            end
          end
        end
      end
      BK_RES0: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ok_nxt    = cmd_r.res0.kind;
          oval_nxt  = cmd_r.res0.value;
          olast_nxt = !cmd_r.res1.vld;
          st_nxt    = cmd_r.res1.vld ? BK_RES1 : BK_IDLE;
        end
      end
      BK_RES1: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ok_nxt    = cmd_r.res1.kind;
          oval_nxt  = cmd_r.res1.value;
          olast_nxt = 1'b1;
          st_nxt    = BK_IDLE;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    ok_r    <= ok_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= BK_IDLE;
      fetched_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      fetched_r <= fetched_nxt;
      ov_r      <= ov_nxt;
    end
  end

endmodule

// ===== hdl/expression_lexer.sv =====
// An item's first result passes the command queue and the back end's command register before
// it reaches the output register; name characters also wait on the registered buffer read.
// Throughput: one item per cycle, while in_full is low, into a two-entry command queue; the
// back end takes each command before its results, which pass through its single output register.
// Input stalls while the queue is full and while a name run is being read from the buffer.
// Reset (rst_n, synchronous, active low) empties the queue and output and idles the lexer.
module expression_lexer #(
  parameter int unsigned MAX_NAME_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_char_code,
  input  logic        in_start_of_text,
  input  logic        in_push,
  output logic        in_full,
  output logic [2:0]  out_kind,
  output logic [31:0] out_value,
  output logic        out_last,
  output logic        out_empty,
  input  logic        out_pop
);
  import elx_pkg::*;

  localparam int unsigned AW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;

  // Front end to queue.
  cmd_t          f_cmd;
  logic          f_push;
  logic          q_full;

  // Queue to back end.
  cmd_t          q_data;
  logic          q_empty;
  logic          q_pop;

  // Name buffer ports and the run handshake between back and front.
  logic          buf_we;
  logic [AW-1:0] buf_waddr;
  logic [7:0]    buf_wdata;
  logic [AW-1:0] buf_raddr;
  logic [7:0]    buf_rdata;
  logic          run_done;

  // The front end runs the tokenizer state machine one item per cycle while in_full is low. It writes
  // name characters into the buffer and turns every item that has results into one
  // command: an optional name run, then up to two plain results.
  elx_front #(
    .MAX_NAME_LEN (MAX_NAME_LEN),
    .AW           (AW)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_char_code     (in_char_code),
    .in_start_of_text (in_start_of_text),
    .in_push          (in_push),
    .in_full          (in_full),
    .q_full           (q_full),
    .run_done         (run_done),
    .cmd_push         (f_push),
    .cmd              (f_cmd),
    .buf_we           (buf_we),
    .buf_waddr        (buf_waddr),
    .buf_wdata        (buf_wdata)
  );

  // The buffered name lives in a small RAM; the front end writes it and the back end
  // reads it out when the name is closed.
  elx_ram #(
    .WIDTH (8),
    .DEPTH (MAX_NAME_LEN),
    .AW    (AW)
  ) u_name_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // Short command queue that lets the front end keep taking characters while the
  // back end waits on the result side.
  elx_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  // The back end expands each command into result items in order and marks the
  // final one of each command as last.
  elx_back #(
    .MAX_NAME_LEN (MAX_NAME_LEN),
    .AW           (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .buf_raddr (buf_raddr),
    .buf_rdata (buf_rdata),
    .run_done  (run_done),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_last  (out_last),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule
